@@ hw/rtl/fpwm_pkg.sv @@
// Shared constants, types and reset values for the four-channel PWM block.
`timescale 1ns / 1ps
`default_nettype none

package fpwm_pkg;

    localparam int NUM_CH       = 4;
    localparam int NUM_REGS     = 2 * NUM_CH;
    localparam int CODE_W       = 10;
    localparam int MV_W         = 12;
    localparam int DUTY_W       = 5;
    localparam int PHASE_W      = 6;

    // PWM period in ticks; legal range 4 to 63 (the counters are PHASE_W bits)
    localparam int PERIOD_TICKS = 40;

    // ADC scaling: mv = floor(code * FULL_SCALE_MV / CODE_MAX)
    localparam int FULL_SCALE_MV = 3300;
    localparam int CODE_MAX      = 1023;
    // wide enough for code*3300 and (threshold+1)*1023
    localparam int PROD_W        = 23;

    // APB register window
    localparam int APB_DW    = 32;
    localparam int REG_IDX_W = $clog2(NUM_REGS);
    localparam int APB_AW    = REG_IDX_W + 2;

    // item command codes
    localparam logic CMD_TICK   = 1'b0;
    localparam logic CMD_SAMPLE = 1'b1;

    // duty selections
    localparam logic [DUTY_W-1:0] DUTY_RESET = 5'd20;
    localparam logic [DUTY_W-1:0] DUTY_SLOW  = 5'd2;
    localparam logic [DUTY_W-1:0] DUTY_FAST  = 5'd3;

    // register order: white_ch0, black_ch0, white_ch1, black_ch1, ...
    localparam logic [MV_W-1:0] THRESH_RESET [NUM_REGS] = '{
        12'd900, 12'd500, 12'd900, 12'd700, 12'd2100, 12'd1950, 12'd1100, 12'd500
    };

    typedef logic [NUM_CH-1:0][CODE_W-1:0] t_code_vec;
    typedef logic [NUM_CH-1:0][DUTY_W-1:0] t_duty_vec;

    typedef struct packed {
        logic [MV_W-1:0] white;
        logic [MV_W-1:0] black;
    } t_thresh;

    typedef t_thresh [NUM_CH-1:0] t_thresh_vec;

    typedef struct packed {
        logic tick;
        logic sample;
    } t_step_ctl;

endpackage

`default_nettype wire

@@ hw/rtl/fpwm_in_if.sv @@
// Input channel: valid/ready handshake carrying one tick or sample item.
`timescale 1ns / 1ps
`default_nettype none

interface fpwm_in_if;
    logic                        valid;
    logic                        ready;
    logic                        cmd;
    logic [fpwm_pkg::CODE_W-1:0] code_ch0;
    logic [fpwm_pkg::CODE_W-1:0] code_ch1;
    logic [fpwm_pkg::CODE_W-1:0] code_ch2;
    logic [fpwm_pkg::CODE_W-1:0] code_ch3;

    modport source (output valid, cmd, code_ch0, code_ch1, code_ch2, code_ch3,
                    input ready);
    modport sink (input valid, cmd, code_ch0, code_ch1, code_ch2, code_ch3,
                  output ready);
endinterface

`default_nettype wire

@@ hw/rtl/fpwm_out_if.sv @@
// Output channel: valid/ready handshake carrying one result item.
`timescale 1ns / 1ps
`default_nettype none

interface fpwm_out_if;
    logic                         valid;
    logic                         ready;
    logic [fpwm_pkg::NUM_CH-1:0]  motor_pins;
    logic [fpwm_pkg::DUTY_W-1:0]  chosen_duty_ch0;
    logic [fpwm_pkg::DUTY_W-1:0]  chosen_duty_ch1;
    logic [fpwm_pkg::DUTY_W-1:0]  chosen_duty_ch2;
    logic [fpwm_pkg::DUTY_W-1:0]  chosen_duty_ch3;
    logic [fpwm_pkg::PHASE_W-1:0] period_phase;

    modport source (output valid, motor_pins, chosen_duty_ch0, chosen_duty_ch1,
                    chosen_duty_ch2, chosen_duty_ch3, period_phase,
                    input ready);
    modport sink (input valid, motor_pins, chosen_duty_ch0, chosen_duty_ch1,
                  chosen_duty_ch2, chosen_duty_ch3, period_phase,
                  output ready);
endinterface

`default_nettype wire

@@ hw/rtl/four_channel_pwm_with_hysteresis_select.sv @@
// Top level: four-channel PWM with hysteresis duty select, APB thresholds.
`timescale 1ns / 1ps
`default_nettype none

// Takes transactions on the input channel: cmd 0 is one PWM tick, cmd 1 a set
// of four 10-bit ADC codes. Each transaction yields exactly one result
// transaction (input register, then the state registers, which double as the
// result register), and a steady stream runs at one transaction per clock
// while results are taken. Input ready drops only while both stages
// are full and the result is not being taken. Samples compare floor(code*3300/
// 1023) mV against per-channel black/white thresholds to pick a duty; ticks
// run a PERIOD_TICKS-long period, latching the selected duties at its start.
// Thresholds are 12-bit registers at APB byte addresses 0x00 to 0x1C in the
// order white/black for channel 0, 1, 2, 3; write them only while idle.
module four_channel_pwm_with_hysteresis_select (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    fpwm_in_if.sink                            i_in,
    fpwm_out_if.source                         o_out,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [fpwm_pkg::APB_AW-1:0]   paddr,
    input  wire logic [fpwm_pkg::APB_DW-1:0]   pwdata,
    output logic      [fpwm_pkg::APB_DW-1:0]   prdata,
    output logic                               pready
);
    import fpwm_pkg::*;

    logic        r_in_valid;
    logic        r_in_cmd;
    t_code_vec   r_in_codes;
    logic        r_out_valid;

    logic        advance;
    logic        step;
    t_step_ctl   ctl;
    t_thresh_vec thresh;
    t_duty_vec   selected;
    logic [NUM_CH-1:0]  pins;
    logic [PHASE_W-1:0] phase;

    // the result stage frees up when empty or when its transaction is taken
    assign advance    = !r_out_valid || o_out.ready;
    assign step       = r_in_valid && advance;
    assign i_in.ready = !r_in_valid || advance;

    assign ctl.tick   = step && (r_in_cmd == CMD_TICK);
    assign ctl.sample = step && (r_in_cmd == CMD_SAMPLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_in.ready) begin
                r_in_valid <= i_in.valid;
            end
            if (advance) begin
                r_out_valid <= r_in_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_in_cmd      <= i_in.cmd;
            r_in_codes[0] <= i_in.code_ch0;
            r_in_codes[1] <= i_in.code_ch1;
            r_in_codes[2] <= i_in.code_ch2;
            r_in_codes[3] <= i_in.code_ch3;
        end
    end

    fpwm_cfg u_cfg (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .o_thresh (thresh)
    );

    fpwm_sel u_sel (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ctl      (ctl),
        .i_codes    (r_in_codes),
        .i_thresh   (thresh),
        .o_selected (selected)
    );

    fpwm_timer u_timer (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ctl      (ctl),
        .i_selected (selected),
        .o_pins     (pins),
        .o_phase    (phase)
    );

    // state only moves when the previous result has gone, so it is the result
    assign o_out.valid           = r_out_valid;
    assign o_out.motor_pins      = pins;
    assign o_out.chosen_duty_ch0 = selected[0];
    assign o_out.chosen_duty_ch1 = selected[1];
    assign o_out.chosen_duty_ch2 = selected[2];
    assign o_out.chosen_duty_ch3 = selected[3];
    assign o_out.period_phase    = phase;

endmodule

`default_nettype wire

@@ hw/rtl/fpwm_cfg.sv @@
// APB threshold register file for the four hysteresis channels.
`timescale 1ns / 1ps
`default_nettype none

module fpwm_cfg (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [fpwm_pkg::APB_AW-1:0]   paddr,
    input  wire logic [fpwm_pkg::APB_DW-1:0]   pwdata,
    output logic      [fpwm_pkg::APB_DW-1:0]   prdata,
    output logic                               pready,
    output fpwm_pkg::t_thresh_vec              o_thresh
);
    import fpwm_pkg::*;

    logic [MV_W-1:0]      r_regs [NUM_REGS];
    logic [REG_IDX_W-1:0] reg_idx;
    logic                 wr_en;

    assign reg_idx = paddr[APB_AW-1:2];
    assign wr_en   = psel && penable && pwrite;
    assign pready  = 1'b1;
    assign prdata  = APB_DW'(r_regs[reg_idx]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_REGS; i++) begin
                r_regs[i] <= THRESH_RESET[i];
            end
        end else if (wr_en) begin
            r_regs[reg_idx] <= pwdata[MV_W-1:0];
        end
    end

    for (genvar ch = 0; ch < NUM_CH; ch++) begin : g_ch
        assign o_thresh[ch].white = r_regs[2*ch];
        assign o_thresh[ch].black = r_regs[2*ch+1];
    end

endmodule

`default_nettype wire

@@ hw/rtl/fpwm_sel.sv @@
// Hysteresis duty selection: ADC code scaling and threshold compare per channel.
`timescale 1ns / 1ps
`default_nettype none

module fpwm_sel (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  fpwm_pkg::t_step_ctl        i_ctl,
    input  fpwm_pkg::t_code_vec        i_codes,
    input  fpwm_pkg::t_thresh_vec      i_thresh,
    output fpwm_pkg::t_duty_vec        o_selected
);
    import fpwm_pkg::*;

    t_duty_vec r_sel;
    t_duty_vec n_sel;

    // floor(p/1023) < black  <=>  p < black*1023
    // floor(p/1023) > white  <=>  p >= (white+1)*1023
    for (genvar ch = 0; ch < NUM_CH; ch++) begin : g_ch
        localparam logic [DUTY_W-1:0] BLACK_DUTY = (ch % 2 == 0) ? DUTY_SLOW : DUTY_FAST;
        localparam logic [DUTY_W-1:0] WHITE_DUTY = (ch % 2 == 0) ? DUTY_FAST : DUTY_SLOW;

        logic [PROD_W-1:0] prod;
        logic [PROD_W-1:0] black_lim;
        logic [PROD_W-1:0] white_lim;
        logic              below;
        logic              above;

        assign prod      = PROD_W'(i_codes[ch]) * PROD_W'(FULL_SCALE_MV);
        assign black_lim = PROD_W'(i_thresh[ch].black) * PROD_W'(CODE_MAX);
        assign white_lim = (PROD_W'(i_thresh[ch].white) + PROD_W'(1)) * PROD_W'(CODE_MAX);
        assign below     = prod < black_lim;
        assign above     = prod >= white_lim;

        // white test wins when both hold
        always_comb begin
            n_sel[ch] = r_sel[ch];
            if (above) begin
                n_sel[ch] = WHITE_DUTY;
            end else if (below) begin
                n_sel[ch] = BLACK_DUTY;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_CH; i++) begin
                r_sel[i] <= DUTY_RESET;
            end
        end else if (i_ctl.sample) begin
            r_sel <= n_sel;
        end
    end

    assign o_selected = r_sel;

endmodule

`default_nettype wire

@@ hw/rtl/fpwm_timer.sv @@
// PWM period and duty counters, duty latch and pin drive.
`timescale 1ns / 1ps
`default_nettype none

module fpwm_timer (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  fpwm_pkg::t_step_ctl                i_ctl,
    input  fpwm_pkg::t_duty_vec                i_selected,
    output logic      [fpwm_pkg::NUM_CH-1:0]   o_pins,
    output logic      [fpwm_pkg::PHASE_W-1:0]  o_phase
);
    import fpwm_pkg::*;

    logic [PHASE_W-1:0] r_period;
    logic [PHASE_W-1:0] r_duty;
    t_duty_vec          r_latched;
    logic [NUM_CH-1:0]  r_pins;

    logic [PHASE_W-1:0] n_period;
    logic [PHASE_W-1:0] n_duty;
    t_duty_vec          n_latched;
    logic [NUM_CH-1:0]  n_pins;

    logic               period_start;
    logic [PHASE_W-1:0] duty_now;
    logic [PHASE_W-1:0] period_inc;

    assign period_start = (r_period == '0);
    assign duty_now     = period_start ? '0 : r_duty;
    assign period_inc   = r_period + PHASE_W'(1);

    always_comb begin
        n_latched = period_start ? i_selected : r_latched;
        n_pins    = period_start ? '1 : r_pins;
        // a zero duty rises and drops on the same tick
        for (int ch = 0; ch < NUM_CH; ch++) begin
            if (duty_now == PHASE_W'(n_latched[ch])) begin
                n_pins[ch] = 1'b0;
            end
        end
        n_duty   = duty_now + PHASE_W'(1);
        n_period = (period_inc >= PHASE_W'(PERIOD_TICKS)) ? '0 : period_inc;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_period  <= '0;
            r_duty    <= '0;
            r_latched <= '0;
            r_pins    <= '0;
        end else if (i_ctl.tick) begin
            r_period  <= n_period;
            r_duty    <= n_duty;
            r_latched <= n_latched;
            r_pins    <= n_pins;
        end
    end

    assign o_pins  = r_pins;
    assign o_phase = r_period;

`ifndef NO_ASSERTIONS
    a_period_range : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_period < PHASE_W'(PERIOD_TICKS))
        else $error("period counter out of range");

    a_sample_holds : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rst_n && i_ctl.sample && !i_ctl.tick |=> $stable(r_period) && $stable(r_pins))
        else $error("sample transaction moved the PWM timing");

    a_start_duty : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rst_n && i_ctl.tick && (r_period == '0) |=> r_duty == PHASE_W'(1))
        else $error("duty count not restarted at period start");

    a_pins_fall_only : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rst_n && i_ctl.tick && (r_period != '0) |=> (r_pins & ~$past(r_pins)) == '0)
        else $error("pin rose in mid-period");
`endif

endmodule

`default_nettype wire
